// ===== src/rpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared widths, constants and types for the repulsive pair force pipeline.
// ----------------------------------------------------------------------------
package rpf_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int TYPE_BITS = 8;
	localparam int INT_FRAC  = 32;
	localparam int MAG_BITS  = 64;

	// clamp value, acts as infinity
	localparam logic [MAG_BITS-1:0] BIG = MAG_BITS'(1) << (MAG_BITS - 2);

	localparam logic [TYPE_BITS-1:0] TYPE_LJ = TYPE_BITS'(1);

	// 2^(-1/3) in 21 fractional bits
	localparam int                  SIGMA_SH = 21;
	localparam logic [SIGMA_SH-1:0] SIGMA_K  = SIGMA_SH'(1664510);

	localparam int RAD_BITS  = WORD_BITS + 2 * INT_FRAC - FRAC_BITS;
	localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
	localparam int DEN_BITS  = (ROOT_BITS > WORD_BITS) ? ROOT_BITS : WORD_BITS;
	localparam int NUM_BITS  = MAG_BITS + INT_FRAC;

	localparam int STAGES     = 8;
	localparam int DIV_STEPS  = (MAG_BITS + STAGES - 1) / STAGES;
	localparam int SQRT_STEPS = (ROOT_BITS + STAGES - 1) / STAGES;
	localparam int UNIT_LAT   = STAGES + 1;
	localparam int MUL_LAT    = 3;

	typedef logic [MAG_BITS-1:0]         mag_t;
	typedef logic [ROOT_BITS-1:0]        root_t;
	typedef logic [DEN_BITS-1:0]         den_t;
	typedef logic [WORD_BITS-1:0]        word_t;
	typedef logic signed [WORD_BITS-1:0] sword_t;

	// fixed point shift applied after a product or before a quotient
	typedef enum logic {
		SH_FRAC = 1'b0,
		SH_INT  = 1'b1
	} shift_t;

endpackage

// ===== src/rpf_mul.sv =====
// ----------------------------------------------------------------------------
// rpf_mul
// Clamped fixed point magnitude multiplier, three register stages:
// partial products, sum, shift and clamp.
// ----------------------------------------------------------------------------
module rpf_mul import rpf_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  mag_t   a,
	input  mag_t   b,
	input  shift_t sh,
	output mag_t   p
);

	localparam int HB = MAG_BITS / 2;
	localparam int FW = 2 * MAG_BITS;

	mag_t            p00_s1, p01_s1, p10_s1, p11_s1;
	logic            zero_s1, big_s1;
	shift_t          sh_s1;
	logic [FW-1:0]   full_s2;
	logic            zero_s2, big_s2;
	shift_t          sh_s2;
	mag_t            p_s3;
	logic [FW-1:0]   shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= MAG_BITS'(a[HB-1:0]) * MAG_BITS'(b[HB-1:0]);
			p01_s1  <= MAG_BITS'(a[HB-1:0]) * MAG_BITS'(b[MAG_BITS-1:HB]);
			p10_s1  <= MAG_BITS'(a[MAG_BITS-1:HB]) * MAG_BITS'(b[HB-1:0]);
			p11_s1  <= MAG_BITS'(a[MAG_BITS-1:HB]) * MAG_BITS'(b[MAG_BITS-1:HB]);
			zero_s1 <= (a == '0) || (b == '0);
			big_s1  <= (a >= BIG) || (b >= BIG);
			sh_s1   <= sh;

			full_s2 <= FW'(p00_s1) + (FW'(p01_s1) << HB) + (FW'(p10_s1) << HB)
				+ (FW'(p11_s1) << MAG_BITS);
			zero_s2 <= zero_s1;
			big_s2  <= big_s1;
			sh_s2   <= sh_s1;

			if (zero_s2) begin
				p_s3 <= '0;
			end else if (big_s2 || (|shifted[FW-1:MAG_BITS-2])) begin
				p_s3 <= BIG;
			end else begin
				p_s3 <= shifted[MAG_BITS-1:0];
			end
		end
	end

	assign shifted = (sh_s2 == SH_INT) ? (full_s2 >> INT_FRAC) : (full_s2 >> FRAC_BITS);
	assign p       = p_s3;

endmodule

// ===== src/rpf_div.sv =====
// ----------------------------------------------------------------------------
// rpf_div
// Pipelined restoring divider: floor(n * 2^sh / d), clamped at the limit.
// One setup stage, then a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
module rpf_div import rpf_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  mag_t   n,
	input  shift_t sh,
	input  den_t   d,
	output mag_t   q
);

	localparam int REM_BITS = DEN_BITS + 1;

	logic [NUM_BITS-1:0] num;
	logic                over_in;

	logic [REM_BITS-1:0] rem_q  [STAGES+1];
	mag_t                lo_q   [STAGES+1];
	mag_t                quo_q  [STAGES+1];
	logic                over_q [STAGES+1];
	den_t                den_q  [STAGES+1];

	logic [REM_BITS-1:0] rem_d [STAGES];
	mag_t                lo_d  [STAGES];
	mag_t                quo_d [STAGES];

	assign num     = (sh == SH_INT) ? (NUM_BITS'(n) << INT_FRAC) : (NUM_BITS'(n) << FRAC_BITS);
	assign over_in = (n >= BIG) || ((num >> (MAG_BITS - 2)) >= NUM_BITS'(d));

	always_comb begin
		logic [REM_BITS-1:0] rm;
		mag_t                lo;
		mag_t                qt;
		for (int st = 0; st < STAGES; st++) begin
			rm = rem_q[st];
			lo = lo_q[st];
			qt = quo_q[st];
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (st * DIV_STEPS + j < MAG_BITS) begin
					rm = {rm[REM_BITS-2:0], lo[MAG_BITS-1]};
					lo = lo << 1;
					if (rm >= REM_BITS'(den_q[st])) begin
						rm = rm - REM_BITS'(den_q[st]);
						qt = {qt[MAG_BITS-2:0], 1'b1};
					end else begin
						qt = {qt[MAG_BITS-2:0], 1'b0};
					end
				end
			end
			rem_d[st] = rm;
			lo_d[st]  = lo;
			quo_d[st] = qt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= REM_BITS'(num >> MAG_BITS);
			lo_q[0]   <= num[MAG_BITS-1:0];
			quo_q[0]  <= '0;
			over_q[0] <= over_in;
			den_q[0]  <= d;
			for (int st = 0; st < STAGES; st++) begin
				rem_q[st+1]  <= rem_d[st];
				lo_q[st+1]   <= lo_d[st];
				quo_q[st+1]  <= quo_d[st];
				over_q[st+1] <= over_q[st];
				den_q[st+1]  <= den_q[st];
			end
		end
	end

	assign q = over_q[STAGES] ? BIG : quo_q[STAGES];

endmodule

// ===== src/rpf_sqrt.sv =====
// ----------------------------------------------------------------------------
// rpf_sqrt
// Pipelined digit by digit square root of a word scaled into the internal
// fraction format; one setup stage, then a few root bits per stage.
// ----------------------------------------------------------------------------
module rpf_sqrt import rpf_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t x,
	output root_t root
);

	localparam int RAD_W    = 2 * ROOT_BITS;
	localparam int REM_BITS = ROOT_BITS + 2;

	logic [RAD_W-1:0]    rad_q  [STAGES+1];
	logic [REM_BITS-1:0] rem_q  [STAGES+1];
	root_t               root_q [STAGES+1];

	logic [RAD_W-1:0]    rad_d  [STAGES];
	logic [REM_BITS-1:0] rem_d  [STAGES];
	root_t               root_d [STAGES];

	always_comb begin
		logic [RAD_W-1:0]    rd;
		logic [REM_BITS-1:0] rm;
		logic [REM_BITS-1:0] trial;
		root_t               rt;
		for (int st = 0; st < STAGES; st++) begin
			rd = rad_q[st];
			rm = rem_q[st];
			rt = root_q[st];
			for (int j = 0; j < SQRT_STEPS; j++) begin
				if (st * SQRT_STEPS + j < ROOT_BITS) begin
					rm    = {rm[REM_BITS-3:0], rd[RAD_W-1 -: 2]};
					rd    = rd << 2;
					trial = {rt, 2'b01};
					if (rm >= trial) begin
						rm = rm - trial;
						rt = {rt[ROOT_BITS-2:0], 1'b1};
					end else begin
						rt = {rt[ROOT_BITS-2:0], 1'b0};
					end
				end
			end
			rad_d[st]  = rd;
			rem_d[st]  = rm;
			root_d[st] = rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q[0]  <= RAD_W'(x) << (2 * INT_FRAC - FRAC_BITS);
			rem_q[0]  <= '0;
			root_q[0] <= '0;
			for (int st = 0; st < STAGES; st++) begin
				rad_q[st+1]  <= rad_d[st];
				rem_q[st+1]  <= rem_d[st];
				root_q[st+1] <= root_d[st];
			end
		end
	end

	assign root = root_q[STAGES];

endmodule

// ===== src/repulsive_pair_force_energy.sv =====
// ----------------------------------------------------------------------------
// repulsive_pair_force_energy
// Lennard-Jones 12-6 or harmonic softcore pair force and energy, fixed point,
// deep pipeline taking one pair per cycle while pair_stall is low.
//
//   channel   beat       valid          stall
//   pair      one pair   pair_valid     pair_stall
//   result    one result result_valid   result_stall
//
// One pair enters every cycle while pair_stall is low; each beat passes
// 2*STAGES + 19 register stages (35 as built), set by the input and output
// registers, the two pipelined dividers, the square roots and five multiplier
// groups of three stages each.
// Reset clears only the valid bits; no clearing pass.
// A stalled result freezes the whole pipeline; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module repulsive_pair_force_energy import rpf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pair_valid,
	output logic                 pair_stall,
	input  sword_t               sep_x,
	input  sword_t               sep_y,
	input  sword_t               sep_z,
	input  word_t                dist_squared,
	input  word_t                contact_squared,
	input  word_t                pair_strength,
	input  logic [TYPE_BITS-1:0] type_a,
	input  logic [TYPE_BITS-1:0] type_b,
	output logic                 result_valid,
	input  logic                 result_stall,
	output sword_t               force_x,
	output sword_t               force_y,
	output sword_t               force_z,
	output sword_t               pair_energy,
	output logic                 saturated
);

	localparam int DEPTH = 1 + UNIT_LAT + 4 * MUL_LAT + UNIT_LAT + MUL_LAT + 1;
	localparam logic [4:0] SCALE_2  = 5'd2;
	localparam logic [4:0] SCALE_4  = 5'd4;
	localparam logic [4:0] SCALE_24 = 5'd24;

	typedef struct packed {
		mag_t m;
		logic neg;
	} smag_t;

	typedef struct packed {
		word_t val;
		logic  sat;
	} emit_t;

	typedef struct packed {
		sword_t sx;
		sword_t sy;
		sword_t sz;
		word_t  k;
		word_t  d2;
		logic   lj;
		logic   live;
	} side_t;

	typedef struct packed {
		side_t sd;
		mag_t  q;
		root_t r;
	} grp_b_t;

	typedef struct packed {
		side_t sd;
		mag_t  ck;
		root_t r;
	} grp_c_t;

	typedef struct packed {
		side_t sd;
		mag_t  mb;
		mag_t  ck;
		root_t r;
	} grp_d_t;

	typedef struct packed {
		side_t sd;
		mag_t  mb;
		mag_t  ck;
		root_t r;
		logic  eneg;
		logic  flip;
	} grp_e_t;

	typedef struct packed {
		sword_t sx;
		sword_t sy;
		sword_t sz;
		mag_t   em;
		logic   eneg;
		logic   pneg;
	} grp_f_t;

	typedef struct packed {
		mag_t em;
		logic eneg;
		logic pneg;
		logic nx;
		logic ny;
		logic nz;
	} grp_g_t;

	function automatic smag_t sub_mag(mag_t x, mag_t y);
		smag_t r;
		if (x >= y) begin
			r.neg = 1'b0;
			r.m   = (x >= BIG) ? BIG : x - y;
		end else begin
			r.neg = 1'b1;
			r.m   = (y >= BIG) ? BIG : y - x;
		end
		return r;
	endfunction

	function automatic mag_t scale(mag_t x, logic [4:0] f);
		logic [MAG_BITS+4:0] p;
		p = (MAG_BITS+5)'(x) * (MAG_BITS+5)'(f);
		if (x == '0) begin
			return '0;
		end else if (x >= BIG || p >= (MAG_BITS+5)'(BIG)) begin
			return BIG;
		end
		return p[MAG_BITS-1:0];
	endfunction

	function automatic emit_t emit(mag_t m, logic neg);
		emit_t r;
		mag_t  lim;
		lim   = neg ? (MAG_BITS'(1) << (WORD_BITS - 1)) : ((MAG_BITS'(1) << (WORD_BITS - 1)) - 1'b1);
		r.sat = (m > lim);
		if (r.sat) begin
			r.val = neg ? WORD_BITS'(-lim) : WORD_BITS'(lim);
		end else begin
			r.val = neg ? WORD_BITS'(-m) : WORD_BITS'(m);
		end
		return r;
	endfunction

	function automatic word_t abs_word(sword_t v);
		return v[WORD_BITS-1] ? WORD_BITS'(-v) : word_t'(v);
	endfunction

	logic adv;
	logic vld_q [DEPTH];

	// input stage
	sword_t sx_s1, sy_s1, sz_s1;
	word_t  k_s1, d2_s1, c2_s1, s2_s1;
	logic   lj_s1;
	logic   live_s1;
	logic [WORD_BITS+SIGMA_SH-1:0] sg_hi, sg_lo;
	word_t  s2_in;

	// unit outputs
	mag_t  q_u, ma1_u, ma2_u, mb_u, mc_u, md1_u, md2_u, pm_u, fx_u, fy_u, fz_u;
	root_t r_u, rc_u, c_a;

	side_t  sa_q [UNIT_LAT];
	grp_b_t sb_q [MUL_LAT];
	grp_c_t sc_q [MUL_LAT];
	grp_d_t sd_q [MUL_LAT];
	grp_e_t se_q [MUL_LAT];
	grp_f_t sf_q [UNIT_LAT];
	grp_g_t sg_q [MUL_LAT];

	side_t  sa;
	grp_b_t sb;
	grp_c_t sc;
	grp_d_t sdd;
	grp_e_t se;
	grp_f_t sf;
	grp_g_t sg;

	smag_t  sub_e, sub_v;
	mag_t   em_sel, num_sel;
	logic   eneg_sel, pneg_sel;

	emit_t  ox, oy, oz, oe;
	mag_t   em_out;

	sword_t fx_q, fy_q, fz_q, en_q;
	logic   sat_q;

	assign adv        = !vld_q[DEPTH-1] || !result_stall;
	assign pair_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= pair_valid;
			for (int i = 1; i < DEPTH; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// sigma squared from the contact distance
	assign sg_hi = (WORD_BITS+SIGMA_SH)'(contact_squared >> SIGMA_SH)
		* (WORD_BITS+SIGMA_SH)'(SIGMA_K);
	assign sg_lo = (WORD_BITS+SIGMA_SH)'(contact_squared[SIGMA_SH-1:0])
		* (WORD_BITS+SIGMA_SH)'(SIGMA_K);
	assign s2_in = WORD_BITS'(sg_hi + (sg_lo >> SIGMA_SH));

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1 <= sep_x;
			sy_s1 <= sep_y;
			sz_s1 <= sep_z;
			k_s1  <= pair_strength;
			d2_s1 <= (dist_squared == '0) ? WORD_BITS'(1) : dist_squared;
			c2_s1 <= contact_squared;
			s2_s1 <= s2_in;
			lj_s1 <= (type_a == TYPE_LJ) && (type_b == TYPE_LJ);
		end
	end

	// cut off test
	assign live_s1 = lj_s1
		? ((WORD_BITS+5)'(d2_s1) * (WORD_BITS+5)'(4) <= (WORD_BITS+5)'(s2_s1) * (WORD_BITS+5)'(25))
		: (d2_s1 <= c2_s1);

	rpf_div u_div_q (
		.clk (clk),
		.en  (adv),
		.n   (MAG_BITS'(s2_s1)),
		.sh  (SH_INT),
		.d   (DEN_BITS'(d2_s1)),
		.q   (q_u)
	);

	rpf_sqrt u_sqrt_r (
		.clk  (clk),
		.en   (adv),
		.x    (d2_s1),
		.root (r_u)
	);

	rpf_sqrt u_sqrt_rc (
		.clk  (clk),
		.en   (adv),
		.x    (c2_s1),
		.root (rc_u)
	);

	assign sa  = sa_q[UNIT_LAT-1];
	assign c_a = rc_u - r_u;

	// q*q or c*c, and c*k
	rpf_mul u_mul_a1 (
		.clk (clk),
		.en  (adv),
		.a   (sa.lj ? q_u : MAG_BITS'(c_a)),
		.b   (sa.lj ? q_u : MAG_BITS'(c_a)),
		.sh  (SH_INT),
		.p   (ma1_u)
	);

	rpf_mul u_mul_a2 (
		.clk (clk),
		.en  (adv),
		.a   (MAG_BITS'(c_a)),
		.b   (MAG_BITS'(sa.k)),
		.sh  (SH_FRAC),
		.p   (ma2_u)
	);

	assign sb = sb_q[MUL_LAT-1];

	// q^3, or softcore energy
	rpf_mul u_mul_b (
		.clk (clk),
		.en  (adv),
		.a   (ma1_u),
		.b   (sb.sd.lj ? sb.q : MAG_BITS'(sb.sd.k)),
		.sh  (sb.sd.lj ? SH_INT : SH_FRAC),
		.p   (mb_u)
	);

	assign sc = sc_q[MUL_LAT-1];

	rpf_mul u_mul_c (
		.clk (clk),
		.en  (adv),
		.a   (mb_u),
		.b   (mb_u),
		.sh  (SH_INT),
		.p   (mc_u)
	);

	assign sdd   = sd_q[MUL_LAT-1];
	assign sub_e = sub_mag(mc_u, sdd.mb);
	assign sub_v = sub_mag(scale(mc_u, SCALE_2), sdd.mb);

	rpf_mul u_mul_d1 (
		.clk (clk),
		.en  (adv),
		.a   (sub_e.m),
		.b   (MAG_BITS'(sdd.sd.k)),
		.sh  (SH_FRAC),
		.p   (md1_u)
	);

	rpf_mul u_mul_d2 (
		.clk (clk),
		.en  (adv),
		.a   (sub_v.m),
		.b   (MAG_BITS'(sdd.sd.k)),
		.sh  (SH_FRAC),
		.p   (md2_u)
	);

	assign se = se_q[MUL_LAT-1];

	always_comb begin
		em_sel   = '0;
		num_sel  = '0;
		eneg_sel = 1'b0;
		pneg_sel = se.sd.lj ? !se.flip : 1'b1;
		if (se.sd.live) begin
			if (se.sd.lj) begin
				em_sel   = scale(md1_u, SCALE_4);
				num_sel  = scale(md2_u, SCALE_24);
				eneg_sel = se.eneg;
			end else begin
				em_sel  = se.mb;
				num_sel = scale(se.ck, SCALE_2);
			end
		end
	end

	rpf_div u_div_p (
		.clk (clk),
		.en  (adv),
		.n   (num_sel),
		.sh  (se.sd.lj ? SH_FRAC : SH_INT),
		.d   (se.sd.lj ? DEN_BITS'(se.sd.d2) : DEN_BITS'(se.r)),
		.q   (pm_u)
	);

	assign sf = sf_q[UNIT_LAT-1];

	rpf_mul u_mul_fx (
		.clk (clk),
		.en  (adv),
		.a   (pm_u),
		.b   (MAG_BITS'(abs_word(sf.sx))),
		.sh  (SH_INT),
		.p   (fx_u)
	);

	rpf_mul u_mul_fy (
		.clk (clk),
		.en  (adv),
		.a   (pm_u),
		.b   (MAG_BITS'(abs_word(sf.sy))),
		.sh  (SH_INT),
		.p   (fy_u)
	);

	rpf_mul u_mul_fz (
		.clk (clk),
		.en  (adv),
		.a   (pm_u),
		.b   (MAG_BITS'(abs_word(sf.sz))),
		.sh  (SH_INT),
		.p   (fz_u)
	);

	assign sg = sg_q[MUL_LAT-1];

	// side data delay lines
	always_ff @(posedge clk) begin
		if (adv) begin
			sa_q[0] <= '{sx: sx_s1, sy: sy_s1, sz: sz_s1, k: k_s1, d2: d2_s1,
				lj: lj_s1, live: live_s1};
			for (int i = 1; i < UNIT_LAT; i++) begin
				sa_q[i] <= sa_q[i-1];
			end
			sb_q[0] <= '{sd: sa, q: q_u, r: r_u};
			sc_q[0] <= '{sd: sb.sd, ck: ma2_u, r: sb.r};
			sd_q[0] <= '{sd: sc.sd, mb: mb_u, ck: sc.ck, r: sc.r};
			se_q[0] <= '{sd: sdd.sd, mb: sdd.mb, ck: sdd.ck, r: sdd.r,
				eneg: sub_e.neg, flip: sub_v.neg};
			sg_q[0] <= '{em: sf.em, eneg: sf.eneg, pneg: sf.pneg,
				nx: sf.sx[WORD_BITS-1], ny: sf.sy[WORD_BITS-1], nz: sf.sz[WORD_BITS-1]};
			for (int i = 1; i < MUL_LAT; i++) begin
				sb_q[i] <= sb_q[i-1];
				sc_q[i] <= sc_q[i-1];
				sd_q[i] <= sd_q[i-1];
				se_q[i] <= se_q[i-1];
				sg_q[i] <= sg_q[i-1];
			end
			sf_q[0] <= '{sx: se.sd.sx, sy: se.sd.sy, sz: se.sd.sz, em: em_sel,
				eneg: eneg_sel, pneg: pneg_sel};
			for (int i = 1; i < UNIT_LAT; i++) begin
				sf_q[i] <= sf_q[i-1];
			end
		end
	end

	// output saturation
	assign em_out = (sg.em >= BIG) ? BIG : (sg.em >> (INT_FRAC - FRAC_BITS));
	assign ox     = emit(fx_u, sg.pneg != sg.nx);
	assign oy     = emit(fy_u, sg.pneg != sg.ny);
	assign oz     = emit(fz_u, sg.pneg != sg.nz);
	assign oe     = emit(em_out, sg.eneg);

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_q  <= sword_t'(ox.val);
			fy_q  <= sword_t'(oy.val);
			fz_q  <= sword_t'(oz.val);
			en_q  <= sword_t'(oe.val);
			sat_q <= ox.sat || oy.sat || oz.sat || oe.sat;
		end
	end

	assign result_valid = vld_q[DEPTH-1];
	assign force_x      = fx_q;
	assign force_y      = fy_q;
	assign force_z      = fz_q;
	assign pair_energy  = en_q;
	assign saturated    = sat_q;

endmodule

// ===== src/rpf_checker.sv =====
// ----------------------------------------------------------------------------
// rpf_checker
// Port level checks on the pair and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module rpf_checker import rpf_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   pair_valid,
	input logic   pair_stall,
	input logic   result_valid,
	input logic   result_stall,
	input sword_t force_x,
	input sword_t force_y,
	input sword_t force_z,
	input sword_t pair_energy,
	input logic   saturated
);

	localparam sword_t MAXV = sword_t'({1'b0, {(WORD_BITS-1){1'b1}}});
	localparam sword_t MINV = sword_t'({1'b1, {(WORD_BITS-1){1'b0}}});

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(force_x) && $stable(force_y)
			&& $stable(force_z) && $stable(pair_energy) && $stable(saturated))
		else $error("result payload changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> result_valid && result_stall)
		else $error("pair stalled without a stalled result");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> (force_x == MAXV) || (force_x == MINV)
			|| (force_y == MAXV) || (force_y == MINV)
			|| (force_z == MAXV) || (force_z == MINV)
			|| (pair_energy == MAXV) || (pair_energy == MINV))
		else $error("saturated flag without a clipped value");

endmodule

bind repulsive_pair_force_energy rpf_checker u_rpf_checker (.*);
